[hdl/slcm_pkg.sv]
// Shared types, register map and defaults for the sample level and clip monitor.
`default_nettype none

package slcm_pkg;

   // default configuration of the datapath
   localparam int unsigned SAMPLE_WIDTH_DEF       = 32;
   localparam int unsigned TOTAL_COUNT_WIDTH_DEF  = 48;
   localparam int unsigned WINDOW_COUNT_WIDTH_DEF = 32;

   // fixed field widths
   localparam int unsigned SAMPLE_WORD_WIDTH = 32;
   localparam int unsigned TOTAL_FIELD_WIDTH = 48;
   localparam int unsigned WIN_SUM_WIDTH     = 64;
   localparam int unsigned PEAK_FIELD_WIDTH  = 32;
   localparam int unsigned COUNT_FIELD_WIDTH = 32;
   localparam int unsigned BPS_WIDTH         = 6;

   // register port
   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   typedef enum logic [1:0] {
      CSR_BITS_PER_SAMPLE = 2'd0,
      CSR_SIGNED_SAMPLES  = 2'd1,
      CSR_LEVEL_ENABLE    = 2'd2
   } csr_index_type;

   // register reset values and width limits
   localparam logic [BPS_WIDTH-1:0] BPS_RESET = 6'd16;
   localparam logic [BPS_WIDTH-1:0] BPS_MIN   = 6'd2;

   // request mode codes
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_REPORT = 1'b1;

   typedef struct packed {
      logic                         mode;
      logic [SAMPLE_WORD_WIDTH-1:0] sample_word;
   } req_type;

   typedef struct packed {
      logic                         is_report;
      logic                         sample_clipped;
      logic [TOTAL_FIELD_WIDTH-1:0] samples_total;
      logic [TOTAL_FIELD_WIDTH-1:0] clips_total;
      logic [WIN_SUM_WIDTH-1:0]     window_sum_squares;
      logic signed [WIN_SUM_WIDTH-1:0] window_sum;
      logic [PEAK_FIELD_WIDTH-1:0]  window_peak;
      logic [COUNT_FIELD_WIDTH-1:0] window_count;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/sample_level_and_clip_monitor.sv]
// Sample level and clip monitor top level: register port, pipeline and window accumulators.
// A request passes the input, decode and square stages, then the result register.
// Throughput: one request per cycle while results do not stall; the accumulators close their
// loop in the last stage. A stalled result holds the pipeline stage by stage; empty stages
// still fill behind it. Reset (synchronous, active high) clears all counters and window sums,
// empties the pipeline and restores bits_per_sample 16, signed samples and levels enabled.
`default_nettype none

module sample_level_and_clip_monitor #(
   parameter int unsigned SAMPLE_WIDTH       = slcm_pkg::SAMPLE_WIDTH_DEF,
   parameter int unsigned TOTAL_COUNT_WIDTH  = slcm_pkg::TOTAL_COUNT_WIDTH_DEF,
   parameter int unsigned WINDOW_COUNT_WIDTH = slcm_pkg::WINDOW_COUNT_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire slcm_pkg::req_type                   req_data,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output slcm_pkg::rsp_type                        rsp_data,
   // register port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [slcm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [slcm_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [slcm_pkg::CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic                                     csr_pready
);
   import slcm_pkg::*;

   localparam int unsigned CW = SAMPLE_WIDTH + 1;
   localparam int unsigned SQ_WIDTH = 2 * SAMPLE_WIDTH;

   // configuration
   logic [BPS_WIDTH-1:0] bps_ff;
   logic                 signed_ff;
   logic                 level_en_ff;
   csr_index_type        csr_index;
   logic                 csr_write;

   // pipeline stages
   logic                    s1_v_ff;
   req_type                 s1_data_ff;
   logic                    s2_v_ff;
   logic                    s2_report_ff;
   logic                    s2_clip_ff;
   logic signed [CW-1:0]    s2_centred_ff;
   logic [SAMPLE_WIDTH-1:0] s2_mag_ff;
   logic                    s3_v_ff;
   logic                    s3_report_ff;
   logic                    s3_clip_ff;
   logic signed [CW-1:0]    s3_centred_ff;
   logic [SAMPLE_WIDTH-1:0] s3_mag_ff;
   logic [SQ_WIDTH-1:0]     s3_square_ff;
   logic                    rsp_v_ff;
   rsp_type                 rsp_data_ff;
   rsp_type                 rsp_data_in;

   // decode outputs
   logic                    dec_clip;
   logic signed [CW-1:0]    dec_centred;
   logic [SAMPLE_WIDTH-1:0] dec_mag;

   // flow control
   logic out_free, s3_free, s2_free, s1_free;
   logic s3_move, s2_move, s1_move;

   // accumulators
   logic [TOTAL_COUNT_WIDTH-1:0]  tot_samples_ff, tot_samples_in;
   logic [TOTAL_COUNT_WIDTH-1:0]  tot_clips_ff, tot_clips_in;
   logic [WIN_SUM_WIDTH-1:0]      win_sq_ff, win_sq_in;
   logic signed [WIN_SUM_WIDTH-1:0] win_sum_ff, win_sum_in;
   logic [SAMPLE_WIDTH-1:0]       win_peak_ff, win_peak_in;
   logic [WINDOW_COUNT_WIDTH-1:0] win_count_ff, win_count_in;
   logic [WIN_SUM_WIDTH:0]        sq_add;
   logic [WIN_SUM_WIDTH:0]        sum_add;

   // fit a total counter into its result field
   function automatic logic [TOTAL_FIELD_WIDTH-1:0] fit_total(
      input logic [TOTAL_COUNT_WIDTH-1:0] v
   );
      logic [63:0] w;
      w = 64'(v);
      return w[TOTAL_FIELD_WIDTH-1:0];
   endfunction

   // fit the window count into its result field
   function automatic logic [COUNT_FIELD_WIDTH-1:0] fit_count(
      input logic [WINDOW_COUNT_WIDTH-1:0] v
   );
      logic [63:0] w;
      w = 64'(v);
      return w[COUNT_FIELD_WIDTH-1:0];
   endfunction

   // ---------------------------------------------------------------- register port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff      <= BPS_RESET;
         signed_ff   <= 1'b1;
         level_en_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BITS_PER_SAMPLE: bps_ff      <= csr_pwdata[BPS_WIDTH-1:0];
            CSR_SIGNED_SAMPLES:  signed_ff   <= csr_pwdata[0];
            CSR_LEVEL_ENABLE:    level_en_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_BITS_PER_SAMPLE: csr_prdata = CSR_DATA_WIDTH'(bps_ff);
         CSR_SIGNED_SAMPLES:  csr_prdata = CSR_DATA_WIDTH'(signed_ff);
         CSR_LEVEL_ENABLE:    csr_prdata = CSR_DATA_WIDTH'(level_en_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- flow control
   // each stage moves on when the one after it is empty or moving
   assign out_free = !rsp_v_ff || !rsp_stall;
   assign s3_move  = s3_v_ff && out_free;
   assign s3_free  = !s3_v_ff || out_free;
   assign s2_move  = s2_v_ff && s3_free;
   assign s2_free  = !s2_v_ff || s3_free;
   assign s1_move  = s1_v_ff && s2_free;
   assign s1_free  = !s1_v_ff || s2_free;
   assign req_stall = !s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_v_ff <= req_valid;
         end
         if (s2_free) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_free) begin
            s3_v_ff <= s2_v_ff;
         end
         if (out_free) begin
            rsp_v_ff <= s3_v_ff;
         end
      end
   end

   // ---------------------------------------------------------------- stage 1: input register
   always_ff @(posedge clock) begin
      if (req_valid && s1_free) begin
         s1_data_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------- stage 2: decode
   slcm_sample_decode #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_decode (
      .sample_word     (s1_data_ff.sample_word),
      .bits_per_sample (bps_ff),
      .signed_samples  (signed_ff),
      .clip            (dec_clip),
      .centred         (dec_centred),
      .mag             (dec_mag)
   );

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_report_ff  <= (s1_data_ff.mode == MODE_REPORT);
         s2_clip_ff    <= dec_clip;
         s2_centred_ff <= dec_centred;
         s2_mag_ff     <= dec_mag;
      end
   end

   // ---------------------------------------------------------------- stage 3: square
   always_ff @(posedge clock) begin
      if (s2_move) begin
         s3_report_ff  <= s2_report_ff;
         s3_clip_ff    <= s2_clip_ff;
         s3_centred_ff <= s2_centred_ff;
         s3_mag_ff     <= s2_mag_ff;
         s3_square_ff  <= SQ_WIDTH'(s2_mag_ff) * SQ_WIDTH'(s2_mag_ff);
      end
   end

   // ---------------------------------------------------------------- accumulate and result
   assign sq_add  = {1'b0, win_sq_ff} + (WIN_SUM_WIDTH + 1)'(s3_square_ff);
   assign sum_add = {win_sum_ff[WIN_SUM_WIDTH-1], win_sum_ff}
                  + {{(WIN_SUM_WIDTH + 1 - CW){s3_centred_ff[CW-1]}}, s3_centred_ff};

   always_comb begin
      tot_samples_in = tot_samples_ff;
      tot_clips_in   = tot_clips_ff;
      win_sq_in      = win_sq_ff;
      win_sum_in     = win_sum_ff;
      win_peak_in    = win_peak_ff;
      win_count_in   = win_count_ff;
      rsp_data_in    = '0;

      if (s3_report_ff) begin
         // report the window as held, then clear it
         rsp_data_in.is_report          = 1'b1;
         rsp_data_in.sample_clipped     = 1'b0;
         rsp_data_in.samples_total      = fit_total(tot_samples_ff);
         rsp_data_in.clips_total        = fit_total(tot_clips_ff);
         rsp_data_in.window_sum_squares = win_sq_ff;
         rsp_data_in.window_sum         = win_sum_ff;
         rsp_data_in.window_peak        = PEAK_FIELD_WIDTH'(win_peak_ff);
         rsp_data_in.window_count       = fit_count(win_count_ff);
         win_sq_in    = '0;
         win_sum_in   = '0;
         win_peak_in  = '0;
         win_count_in = '0;
      end else begin
         // saturating totals
         if (tot_samples_ff != '1) begin
            tot_samples_in = tot_samples_ff + 1'b1;
         end
         if (s3_clip_ff && (tot_clips_ff != '1)) begin
            tot_clips_in = tot_clips_ff + 1'b1;
         end
         // window statistics
         if (level_en_ff) begin
            win_sq_in = sq_add[WIN_SUM_WIDTH] ? '1 : sq_add[WIN_SUM_WIDTH-1:0];
            if (sum_add[WIN_SUM_WIDTH] != sum_add[WIN_SUM_WIDTH-1]) begin
               win_sum_in = sum_add[WIN_SUM_WIDTH]
                          ? {1'b1, {(WIN_SUM_WIDTH-1){1'b0}}}
                          : {1'b0, {(WIN_SUM_WIDTH-1){1'b1}}};
            end else begin
               win_sum_in = sum_add[WIN_SUM_WIDTH-1:0];
            end
            if (s3_mag_ff > win_peak_ff) begin
               win_peak_in = s3_mag_ff;
            end
            if (win_count_ff != '1) begin
               win_count_in = win_count_ff + 1'b1;
            end
         end
         rsp_data_in.is_report          = 1'b0;
         rsp_data_in.sample_clipped     = s3_clip_ff;
         rsp_data_in.samples_total      = fit_total(tot_samples_in);
         rsp_data_in.clips_total        = fit_total(tot_clips_in);
         rsp_data_in.window_sum_squares = win_sq_in;
         rsp_data_in.window_sum         = win_sum_in;
         rsp_data_in.window_peak        = PEAK_FIELD_WIDTH'(win_peak_in);
         rsp_data_in.window_count       = fit_count(win_count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_samples_ff <= '0;
         tot_clips_ff   <= '0;
         win_sq_ff      <= '0;
         win_sum_ff     <= '0;
         win_peak_ff    <= '0;
         win_count_ff   <= '0;
      end else if (s3_move) begin
         tot_samples_ff <= tot_samples_in;
         tot_clips_ff   <= tot_clips_in;
         win_sq_ff      <= win_sq_in;
         win_sum_ff     <= win_sum_in;
         win_peak_ff    <= win_peak_in;
         win_count_ff   <= win_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- assertions
   // clipped samples never outrun processed samples
   a_clips_le_samples: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (rsp_data_ff.clips_total <= rsp_data_ff.samples_total))
      else $error("clip total exceeds sample total");

   // a report leaves the window empty
   a_report_clears: assert property (@(posedge clock) disable iff (reset)
      (s3_move && s3_report_ff) |=> ((win_count_ff == '0) && (win_peak_ff == '0)
                                     && (win_sq_ff == '0) && (win_sum_ff == '0)))
      else $error("window not cleared after report");

   // a request leaving the input stage is held in the decode stage
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> s2_v_ff)
      else $error("request lost between input and decode stages");

   // peak never exceeds half scale
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (rsp_data_ff.window_peak
                    <= (PEAK_FIELD_WIDTH'(1) << (SAMPLE_WIDTH - 1))))
      else $error("window peak above half scale");

endmodule

`default_nettype wire

[hdl/slcm_sample_decode.sv]
// Sample decode: width masking, centring, clip detection and magnitude.
`default_nettype none

module slcm_sample_decode #(
   parameter int unsigned SAMPLE_WIDTH = slcm_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic [slcm_pkg::SAMPLE_WORD_WIDTH-1:0] sample_word,
   input  wire logic [slcm_pkg::BPS_WIDTH-1:0]         bits_per_sample,
   input  wire logic                                   signed_samples,
   output logic                                        clip,
   output logic signed [SAMPLE_WIDTH:0]                centred,
   output logic [SAMPLE_WIDTH-1:0]                     mag
);
   import slcm_pkg::*;

   localparam int unsigned CW = SAMPLE_WIDTH + 1;

   logic [BPS_WIDTH-1:0]    bw_eff;
   logic [SAMPLE_WIDTH-1:0] keep_mask;
   logic [SAMPLE_WIDTH-1:0] top_bit;
   logic [SAMPLE_WIDTH-1:0] raw;
   logic                    sign_bit;
   logic signed [CW-1:0]    ext_val;
   logic signed [CW-1:0]    off_val;
   logic [CW-1:0]           neg_val;

   // clamp the configured width into the supported range
   always_comb begin
      if (bits_per_sample < BPS_MIN) begin
         bw_eff = BPS_MIN;
      end else if (bits_per_sample > BPS_WIDTH'(SAMPLE_WIDTH)) begin
         bw_eff = BPS_WIDTH'(SAMPLE_WIDTH);
      end else begin
         bw_eff = bits_per_sample;
      end
   end

   // keep mask over the significant bits, one-hot marker on the top one
   always_comb begin
      for (int i = 0; i < SAMPLE_WIDTH; i++) begin
         keep_mask[i] = (BPS_WIDTH'(i) < bw_eff);
         top_bit[i]   = (BPS_WIDTH'(i + 1) == bw_eff);
      end
   end

   assign raw      = sample_word[SAMPLE_WIDTH-1:0] & keep_mask;
   assign sign_bit = |(raw & top_bit);

   // two's complement: sign-extend from the top significant bit
   always_comb begin
      for (int i = 0; i < SAMPLE_WIDTH; i++) begin
         ext_val[i] = keep_mask[i] ? raw[i] : sign_bit;
      end
      ext_val[CW-1] = sign_bit;
   end

   // offset binary: subtract mid-scale
   assign off_val = $signed({1'b0, raw}) - $signed({1'b0, top_bit});

   assign centred = signed_samples ? ext_val : off_val;

   // full scale: max is mid-scale minus one, min is mid-scale pattern (signed)
   always_comb begin
      if (signed_samples) begin
         clip = (raw == (keep_mask >> 1)) || (raw == top_bit);
      end else begin
         clip = (raw == '0) || (raw == keep_mask);
      end
   end

   // magnitude fits the sample width: at most 2^(width-1)
   assign neg_val = -centred;
   assign mag     = centred[CW-1] ? neg_val[SAMPLE_WIDTH-1:0] : centred[SAMPLE_WIDTH-1:0];

endmodule

`default_nettype wire
